// ===== hw/rtl/bctt_pkg.sv =====
// shared types, constants and helpers for the branch target chain threader
`default_nettype none

package bctt_pkg;

  localparam int TableDepth   = 64;
  localparam int TargetWidth  = 16;
  localparam int MaxChainHops = 100;

  localparam int AddrW     = $clog2(TableDepth);
  localparam int CntW      = $clog2(TableDepth + 1);
  localparam int HopW      = $clog2(MaxChainHops + 1);
  localparam int AluW      = TargetWidth + 2;
  localparam int IndexW    = 6;
  localparam int CountW    = 7;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_NOP   = 2'd1,
    KIND_JUMP  = 2'd2,
    KIND_COND  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMPTY,
    S_RD_I,
    S_ENT,
    S_WALK_RD,
    S_WALK,
    S_SKIP_RD,
    S_SKIP,
    S_FINAL,
    S_EMIT
  } state_e;

  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_e;

  typedef struct packed {
    logic                          operation;
    logic [IndexW-1:0]             entry_index;
    logic [1:0]                    entry_kind;
    logic signed [TargetWidth-1:0] entry_target;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0]             entry_index_res;
    logic signed [TargetWidth-1:0] new_target;
    logic                          changed;
    logic [CountW-1:0]             change_count;
    logic                          last;
  } out_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [TargetWidth-1:0] target;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

  typedef struct packed {
    alu_op_e         op;
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] y;
    logic            lt;
    logic            zero;
  } alu_rsp_t;

  // sign extend a stored target to the shared unit width
  function automatic logic [AluW-1:0] sext_tgt(input logic [TargetWidth-1:0] t);
    return {{(AluW - TargetWidth){t[TargetWidth-1]}}, t};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bctt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module bctt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bctt_alu.sv =====
// shared adder: subtract-compare or increment
`default_nettype none

module bctt_alu (
  input  wire bctt_pkg::alu_req_t req_i,
  output      bctt_pkg::alu_rsp_t rsp_o
);

  logic [bctt_pkg::AluW-1:0] b_op;
  logic [bctt_pkg::AluW-1:0] sum;

  always_comb begin
    b_op = (req_i.op == bctt_pkg::ALU_SUB) ? ~req_i.b : '0;
    sum  = req_i.a + b_op + bctt_pkg::AluW'(1);
  end

  // operands are far narrower than the adder, so the sign bit never overflows
  assign rsp_o.y    = sum;
  assign rsp_o.lt   = sum[bctt_pkg::AluW-1];
  assign rsp_o.zero = (sum == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/bctt_seq.sv =====
// run sequencer: entry scan, chain walk, nop skip and write-back
`default_nettype none

module bctt_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [bctt_pkg::CntW-1:0]    n_i,
  input  wire logic                         out_free_i,
  input  wire bctt_pkg::entry_t             rdata_i,
  output      logic                         busy_o,
  output      logic [bctt_pkg::AddrW-1:0]   rd_addr_o,
  output      bctt_pkg::ram_wr_t            wr_o,
  output      bctt_pkg::res_push_t          push_o
);

  bctt_pkg::state_e                     state_q, state_d;
  logic [bctt_pkg::AddrW-1:0]           i_q, i_d;
  bctt_pkg::kind_e                      k_q, k_d;
  logic [bctt_pkg::TargetWidth-1:0]     tgt_q, tgt_d;
  logic [bctt_pkg::CntW-1:0]            cur_q, cur_d;
  logic [bctt_pkg::CntW-1:0]            idx_q, idx_d;
  logic                                 walk_q, walk_d;
  logic [bctt_pkg::HopW-1:0]            hops_q, hops_d;
  logic [bctt_pkg::CountW-1:0]          chg_cnt_q, chg_cnt_d;
  logic [bctt_pkg::TableDepth-1:0]      visited_q, visited_d;
  logic [bctt_pkg::TargetWidth-1:0]     res_target_q, res_target_d;
  logic                                 res_chg_q, res_chg_d;

  bctt_pkg::alu_req_t                   alu_req;
  bctt_pkg::alu_rsp_t                   alu_rsp;
  logic [bctt_pkg::AddrW-1:0]           cur_addr;
  logic [bctt_pkg::AddrW-1:0]           idx_addr;
  logic                                 last;

  bctt_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign cur_addr = cur_q[bctt_pkg::AddrW-1:0];
  assign idx_addr = idx_q[bctt_pkg::AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bctt_pkg::S_IDLE;
      visited_q <= '0;
      hops_q    <= '0;
      chg_cnt_q <= '0;
      i_q       <= '0;
      walk_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      hops_q    <= hops_d;
      chg_cnt_q <= chg_cnt_d;
      i_q       <= i_d;
      walk_q    <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    tgt_q        <= tgt_d;
    cur_q        <= cur_d;
    idx_q        <= idx_d;
    res_target_q <= res_target_d;
    res_chg_q    <= res_chg_d;
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    k_d          = k_q;
    tgt_d        = tgt_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    walk_d       = walk_q;
    hops_d       = hops_q;
    chg_cnt_d    = chg_cnt_q;
    visited_d    = visited_q;
    res_target_d = res_target_q;
    res_chg_d    = res_chg_q;

    alu_req.op = bctt_pkg::ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;

    rd_addr_o        = i_q;
    wr_o.we          = 1'b0;
    wr_o.addr        = i_q;
    wr_o.data.kind   = k_q;
    wr_o.data.target = bctt_pkg::TargetWidth'(cur_q);
    last             = 1'b0;

    push_o.valid                = 1'b0;
    push_o.item.entry_index_res = bctt_pkg::IndexW'(i_q);
    push_o.item.new_target      = res_target_q;
    push_o.item.changed         = res_chg_q;
    push_o.item.change_count    = chg_cnt_q;
    push_o.item.last            = 1'b0;

    unique case (state_q)
      bctt_pkg::S_IDLE: begin
        if (start_i) begin
          chg_cnt_d = '0;
          i_d       = '0;
          state_d   = (n_i == '0) ? bctt_pkg::S_EMPTY : bctt_pkg::S_RD_I;
        end
      end

      bctt_pkg::S_EMPTY: begin
        push_o.valid                = out_free_i;
        push_o.item.entry_index_res = '0;
        push_o.item.new_target      = '0;
        push_o.item.changed         = 1'b0;
        push_o.item.change_count    = '0;
        push_o.item.last            = 1'b1;
        if (out_free_i) begin
          state_d = bctt_pkg::S_IDLE;
        end
      end

      bctt_pkg::S_RD_I: begin
        rd_addr_o = i_q;
        state_d   = bctt_pkg::S_ENT;
      end

      bctt_pkg::S_ENT: begin
        // target inside the table?
        alu_req.a    = bctt_pkg::sext_tgt(rdata_i.target);
        alu_req.b    = bctt_pkg::AluW'(n_i);
        k_d          = rdata_i.kind;
        tgt_d        = rdata_i.target;
        res_target_d = rdata_i.target;
        res_chg_d    = 1'b0;
        if ((rdata_i.kind == bctt_pkg::KIND_JUMP || rdata_i.kind == bctt_pkg::KIND_COND) &&
            !rdata_i.target[bctt_pkg::TargetWidth-1] && alu_rsp.lt) begin
          visited_d = '0;
          cur_d     = bctt_pkg::CntW'(rdata_i.target);
          hops_d    = '0;
          state_d   = bctt_pkg::S_WALK_RD;
        end else begin
          state_d = bctt_pkg::S_EMIT;
        end
      end

      bctt_pkg::S_WALK_RD: begin
        alu_req.a = bctt_pkg::AluW'(cur_q);
        alu_req.b = bctt_pkg::AluW'(n_i);
        if (alu_rsp.lt && hops_q < bctt_pkg::HopW'(bctt_pkg::MaxChainHops) &&
            !visited_q[cur_addr]) begin
          visited_d[cur_addr] = 1'b1;
          rd_addr_o           = cur_addr;
          state_d             = bctt_pkg::S_WALK;
        end else begin
          walk_d  = 1'b0;
          idx_d   = cur_q;
          state_d = bctt_pkg::S_SKIP_RD;
        end
      end

      bctt_pkg::S_WALK: begin
        // jump target beyond the epilogue?
        alu_req.a = bctt_pkg::AluW'(n_i);
        alu_req.b = bctt_pkg::sext_tgt(rdata_i.target);
        idx_d     = cur_q;
        walk_d    = 1'b0;
        state_d   = bctt_pkg::S_SKIP_RD;
        case (rdata_i.kind)
          bctt_pkg::KIND_NOP: begin
            walk_d = 1'b1;
          end
          bctt_pkg::KIND_JUMP: begin
            if (!rdata_i.target[bctt_pkg::TargetWidth-1] && !alu_rsp.lt) begin
              cur_d   = bctt_pkg::CntW'(rdata_i.target);
              hops_d  = hops_q + 1'b1;
              state_d = bctt_pkg::S_WALK_RD;
            end
          end
          default: begin
          end
        endcase
      end

      bctt_pkg::S_SKIP_RD: begin
        alu_req.a = bctt_pkg::AluW'(idx_q);
        alu_req.b = bctt_pkg::AluW'(n_i);
        if (alu_rsp.lt) begin
          rd_addr_o = idx_addr;
          state_d   = bctt_pkg::S_SKIP;
        end else begin
          // nops run into the end: keep the start
          state_d = walk_q ? bctt_pkg::S_WALK_RD : bctt_pkg::S_FINAL;
        end
      end

      bctt_pkg::S_SKIP: begin
        alu_req.op = bctt_pkg::ALU_INC;
        alu_req.a  = bctt_pkg::AluW'(idx_q);
        if (rdata_i.kind == bctt_pkg::KIND_NOP) begin
          idx_d   = alu_rsp.y[bctt_pkg::CntW-1:0];
          state_d = bctt_pkg::S_SKIP_RD;
        end else begin
          cur_d   = idx_q;
          state_d = walk_q ? bctt_pkg::S_WALK_RD : bctt_pkg::S_FINAL;
        end
      end

      bctt_pkg::S_FINAL: begin
        alu_req.a = bctt_pkg::AluW'(cur_q);
        alu_req.b = bctt_pkg::sext_tgt(tgt_q);
        // conditional branches never move backward
        if (!alu_rsp.zero && !(k_q == bctt_pkg::KIND_COND && alu_rsp.lt)) begin
          wr_o.we      = 1'b1;
          res_target_d = bctt_pkg::TargetWidth'(cur_q);
          res_chg_d    = 1'b1;
          chg_cnt_d    = chg_cnt_q + 1'b1;
        end
        state_d = bctt_pkg::S_EMIT;
      end

      bctt_pkg::S_EMIT: begin
        alu_req.op       = bctt_pkg::ALU_INC;
        alu_req.a        = bctt_pkg::AluW'(i_q);
        last             = (alu_rsp.y[bctt_pkg::CntW-1:0] == n_i);
        push_o.item.last = last;
        push_o.valid     = out_free_i;
        if (out_free_i) begin
          if (last) begin
            state_d = bctt_pkg::S_IDLE;
          end else begin
            i_d     = alu_rsp.y[bctt_pkg::AddrW-1:0];
            state_d = bctt_pkg::S_RD_I;
          end
        end
      end

      default: begin
        state_d = bctt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != bctt_pkg::S_IDLE);

  a_walk_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bctt_pkg::S_WALK |-> $past(state_q) == bctt_pkg::S_WALK_RD)
    else $error("chain step decoded without a read");

  a_skip_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bctt_pkg::S_SKIP |-> $past(state_q) == bctt_pkg::S_SKIP_RD)
    else $error("nop scan decoded without a read");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.item.last) |=> state_q == bctt_pkg::S_IDLE)
    else $error("run continued after its final result");

  a_hop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hops_q <= bctt_pkg::HopW'(bctt_pkg::MaxChainHops))
    else $error("chain hop count beyond limit");

endmodule

`default_nettype wire

// ===== hw/rtl/branch_target_chain_threader.sv =====
// top level of the branch target chain threader
`default_nettype none

// Loads and runs share one input channel. A load writes one table entry, so
// loads stream one per clock while no run is in progress. A run steps
// through the entries in order and delivers one result per entry (a single
// result when the count is zero). Each entry passes through read, decode
// and emit steps; a branch whose target is in the table adds a read and a
// decode step per chain step and per nop scanned, and a write-back step.
// The pace is set by the single read port of the entry table, which the
// sequencer and its shared adder use once per step. Input is stalled for
// the whole run; the result register lets the final result wait while the
// next item enters.
module branch_target_chain_threader (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire bctt_pkg::in_item_t          in_item_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      bctt_pkg::out_item_t         out_item_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [bctt_pkg::CountW-1:0] cfg_wdata_i
);

  logic [bctt_pkg::CountW-1:0] count_q;
  logic [bctt_pkg::CntW-1:0]   n_eff;

  logic                        busy;
  logic                        in_xfer;
  logic                        start_run;
  logic                        out_free;

  bctt_pkg::ram_wr_t           seq_wr;
  bctt_pkg::ram_wr_t           load_wr;
  bctt_pkg::ram_wr_t           ram_wr;
  bctt_pkg::res_push_t         push;
  bctt_pkg::entry_t            rdata;
  logic [bctt_pkg::AddrW-1:0]  rd_addr;

  logic                        out_valid_q;
  bctt_pkg::out_item_t         out_item_q;

  // entry count register; the user must write it only between runs, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // counts above the table depth act as the full table
  assign n_eff = (count_q > bctt_pkg::CountW'(bctt_pkg::TableDepth)) ?
                 bctt_pkg::CntW'(bctt_pkg::TableDepth) : bctt_pkg::CntW'(count_q);

  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !busy;
  assign start_run  = in_xfer && (in_item_i.operation == bctt_pkg::OpRun);

  // loads to slots past the table are dropped
  always_comb begin
    load_wr.we          = in_xfer && (in_item_i.operation == bctt_pkg::OpLoad) &&
                          (bctt_pkg::CountW'(in_item_i.entry_index) <
                           bctt_pkg::CountW'(bctt_pkg::TableDepth));
    load_wr.addr        = bctt_pkg::AddrW'(in_item_i.entry_index);
    load_wr.data.kind   = bctt_pkg::kind_e'(in_item_i.entry_kind);
    load_wr.data.target = in_item_i.entry_target;
  end

  // sequencer writes only while busy, loads only while idle
  assign ram_wr = seq_wr.we ? seq_wr : load_wr;

  bctt_ram #(
    .Width ($bits(bctt_pkg::entry_t)),
    .Depth (bctt_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  bctt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_run),
    .n_i        (n_eff),
    .out_free_i (out_free),
    .rdata_i    (rdata),
    .busy_o     (busy),
    .rd_addr_o  (rd_addr),
    .wr_o       (seq_wr),
    .push_o     (push)
  );

  // result register: free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_item_q <= push.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
